// ===== rtl/gmac_pkg.sv =====
// gmac_pkg: shared types, codes and GF(2^128) helpers for the GHASH accumulator
// depends on: nothing
package gmac_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_UPDATE  = 2'd0;
    localparam logic [1:0] OP_DIGEST  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_IDLE    = 2'd3;

    localparam logic [1:0] REG_KEY_HIGH  = 2'd0;
    localparam logic [1:0] REG_KEY_LOW   = 2'd1;
    localparam logic [1:0] REG_MASK_HIGH = 2'd2;
    localparam logic [1:0] REG_MASK_LOW  = 2'd3;

    localparam logic [4:0] MAX_BYTES = 5'd16;

    typedef struct packed {
        logic [1:0]   op;
        logic [127:0] block;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } push_t;

    // keep the leading n bytes, byte 0 in bits 127:120
    function automatic logic [127:0] byte_keep(input logic [4:0] n);
        logic [127:0] m;
        m = '0;
        for (int b = 0; b < 16; b++)
        begin
            m[127 - 8 * b -: 8] = (5'(b) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    // product in GF(2^128), GCM reflected bit order, reduction x^128+x^7+x^2+x+1
    function automatic logic [127:0] gf_mul(input logic [127:0] x, input logic [127:0] y);
        logic [127:0] a;
        logic [127:0] b;
        logic [254:0] p;
        logic [134:0] hi;
        logic [134:0] r1;
        logic [127:0] h2;
        logic [127:0] r;
        logic [127:0] z;
        for (int i = 0; i < 128; i++)
        begin
            a[i] = x[127 - i];
            b[i] = y[127 - i];
        end
        p = '0;
        for (int k = 0; k < 255; k++)
        begin
            for (int j = 0; j < 128; j++)
            begin
                if ((k - j >= 0) && (k - j <= 127))
                begin
                    p[k] = p[k] ^ (a[j] & b[k - j]);
                end
            end
        end
        hi = {8'b0, p[254:128]};
        r1 = {7'b0, p[127:0]} ^ hi ^ (hi << 1) ^ (hi << 2) ^ (hi << 7);
        h2 = {121'b0, r1[134:128]};
        r  = r1[127:0] ^ h2 ^ (h2 << 1) ^ (h2 << 2) ^ (h2 << 7);
        for (int i = 0; i < 128; i++)
        begin
            z[127 - i] = r[i];
        end
        return z;
    endfunction

endpackage

// ===== rtl/gmac_front.sv =====
// gmac_front: accepts input beats, saturates the byte count, masks the block
// depends on: gmac_pkg
module gmac_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           opcode,
    input  logic [63:0]          block_high,
    input  logic [63:0]          block_low,
    input  logic [4:0]           valid_bytes,
    input  logic                 q_full,
    output gmac_pkg::push_t      q_push
);
    import gmac_pkg::*;

    logic [4:0] n_sat;

    assign in_ready = !q_full;
    assign n_sat    = (valid_bytes > MAX_BYTES) ? MAX_BYTES : valid_bytes;

    // unused opcode is taken and dropped here
    assign q_push.push      = in_valid && in_ready && (opcode != OP_IDLE);
    assign q_push.cmd.op    = opcode;
    assign q_push.cmd.block = {block_high, block_low} & byte_keep(n_sat);

endmodule

// ===== rtl/gmac_queue.sv =====
// gmac_queue: short command queue between front and back
// depends on: gmac_pkg
module gmac_queue #(
    parameter int DEPTH = gmac_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gmac_pkg::push_t  q_push,
    output logic             q_full,
    input  logic             q_pop,
    output logic             q_valid,
    output gmac_pkg::cmd_t   q_head
);
    import gmac_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push_ok;
    logic             pop_ok;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_head  = entry_reg[rd_ptr_reg];
    assign push_ok = q_push.push && !q_full;
    assign pop_ok  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push_ok) - CNT_W'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            entry_reg[wr_ptr_reg] <= q_push.cmd;
        end
    end

endmodule

// ===== rtl/gmac_back.sv =====
// gmac_back: key and mask registers, accumulator, GF(2^128) multiply, tag output
// depends on: gmac_pkg
module gmac_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [63:0]     cfg_data,
    input  logic            q_valid,
    input  gmac_pkg::cmd_t  q_head,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [63:0]     tag_high,
    output logic [63:0]     tag_low
);
    import gmac_pkg::*;

    logic [127:0] key_reg;
    logic [127:0] mask_reg;
    logic [127:0] acc_reg;
    logic [127:0] acc_next;
    logic [127:0] tag_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         is_digest;

    assign is_digest = (q_head.op == OP_DIGEST);
    assign q_pop     = q_valid && (!is_digest || !out_valid_reg || out_ready);

    always_comb
    begin
        acc_next = acc_reg;
        if (q_pop)
        begin
            unique case (q_head.op)
                OP_UPDATE:  acc_next = gf_mul(q_head.block ^ acc_reg, key_reg);
                OP_DIGEST:  acc_next = acc_reg ^ mask_reg;
                OP_RESTART: acc_next = '0;
                default:    acc_next = acc_reg;
            endcase
        end
        out_valid_next = (out_valid_reg && !out_ready) || (q_pop && is_digest);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            mask_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KEY_HIGH:  key_reg[127:64]  <= cfg_data;
                    REG_KEY_LOW:   key_reg[63:0]    <= cfg_data;
                    REG_MASK_HIGH: mask_reg[127:64] <= cfg_data;
                    REG_MASK_LOW:  mask_reg[63:0]   <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && is_digest)
        begin
            tag_reg <= acc_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign tag_high  = tag_reg[127:64];
    assign tag_low   = tag_reg[63:0];

endmodule

// ===== rtl/ghash_gmac_accumulator.sv =====
// ghash_gmac_accumulator: GHASH/GMAC engine top level
// depends on: gmac_pkg, gmac_front, gmac_queue, gmac_back
//
//   channel   signals                                          dir
//   input     in_valid/in_ready, opcode, block_*, valid_bytes  in
//   result    out_valid/out_ready, tag_high, tag_low           out
//   config    cfg_valid/cfg_ready, cfg_index, cfg_data         in
//
// one beat per cycle sustained while no digest waits behind a stalled tag; the
// GF(2^128) multiply is combinational in the back end's accumulator loop
// an accepted input beat is registered in the queue before the back end sees it;
// a tag appears in the cycle after the back end pops its digest beat
// reset clears the key, mask, accumulator, queue and output valid at once
// a stalled tag blocks the back end only at the next digest; the queue then fills
module ghash_gmac_accumulator #(
    parameter int QUEUE_DEPTH = gmac_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic [4:0]  valid_bytes,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] tag_high,
    output logic [63:0] tag_low,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import gmac_pkg::*;

    push_t q_push;
    cmd_t  q_head;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    assign cfg_ready = 1'b1;

    gmac_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .block_high  (block_high),
        .block_low   (block_low),
        .valid_bytes (valid_bytes),
        .q_full      (q_full),
        .q_push      (q_push)
    );

    gmac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_head  (q_head)
    );

    gmac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tag_high  (tag_high),
        .tag_low   (tag_low)
    );

endmodule

// ===== rtl/gmac_checker.sv =====
// gmac_checker: port-level assertions for the GHASH accumulator, bound to the top
// depends on: ghash_gmac_accumulator ports
module gmac_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] tag_high,
    input logic [63:0] tag_low,
    input logic        cfg_ready
);

    // a stalled result beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // a stalled tag keeps its value
    a_tag_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(tag_high) && $stable(tag_low))
        else $error("tag changed while stalled");

    // back end only stalls behind a pending tag, so the queue never stays full otherwise
    a_no_false_full: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(out_valid) |-> in_ready)
        else $error("input stalled with no pending tag");

    // config writes never wait
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind ghash_gmac_accumulator gmac_checker u_gmac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tag_high  (tag_high),
    .tag_low   (tag_low),
    .cfg_ready (cfg_ready)
);
